>>> sv/double_ended_queue_with_search_unit_defines.svh
// ----------------------------------------------------------------------------
// Deque search unit assertion macros
// Shared property shorthands; clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DQS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque search unit: assertion failed");

// Next-cycle implication.
`define DQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque search unit: assertion failed");

`endif

>>> sv/dqs_pkg.sv
// ----------------------------------------------------------------------------
// Deque search unit package
// Widths, operation and status codes, and the per-cell command bundle.
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned OpW          = 3;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountW       = 5;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LOOKUP     = 3'd4,
    OP_REMOVE     = 3'd5
  } op_e;

  localparam logic [StatusW-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL    = 2'd2;
  localparam logic [StatusW-1:0] STATUS_MISSING = 2'd3;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;  // latch the match flag
    logic upd;  // apply the operation
    op_e  op;
  } cell_cmd_t;

endpackage

>>> sv/dqs_cell.sv
// ----------------------------------------------------------------------------
// Deque search cell
// One slot: stored word, valid bit and match flag; shifts to/from neighbors.
// ----------------------------------------------------------------------------
module dqs_cell
  import dqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [DataW-1:0] value_i,
  input  logic [DataW-1:0] left_data_i,
  input  logic             left_valid_i,
  input  logic [DataW-1:0] right_data_i,
  input  logic             right_valid_i,
  input  logic             seen_i,       // a match exists at or before this cell
  output logic [DataW-1:0] data_o,
  output logic             valid_o,
  output logic             match_o
);

  logic [DataW-1:0] data_q, data_d;
  logic             valid_q, valid_d;
  logic             match_q;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    unique case (cmd_i.op)
      OP_PUSH_FRONT: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      OP_PUSH_BACK: begin
        if (!valid_q && left_valid_i) begin
          data_d  = value_i;
          valid_d = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      OP_POP_BACK: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      OP_REMOVE: begin
        if (seen_i) begin
          data_d  = right_data_i;
          valid_d = right_valid_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (cmd_i.cmp) begin
        match_q <= valid_q && (data_q == value_i);
      end
      if (cmd_i.upd) begin
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      data_q <= data_d;
    end
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

>>> sv/double_ended_queue_with_search_unit.sv
// ----------------------------------------------------------------------------
// Double-ended queue with search unit
// Bounded deque of signed words kept in a chain of cells, with value search.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the operation (push front, push back, pop
//   front, pop back, lookup, remove first match), tdata the 32-bit word.
//   Output stream: one result per operation with status, found flag, front
//   and back words (0 when empty), the count and an empty flag.
//   Each operation goes from input transfer to a valid result in these steps:
//   compare in all cells at once, shift the chain, form the result.
//   A new operation is taken in the cycle after the result is loaded, so
//   operations never overlap: one finishes before the next is taken; the
//   sequence of compare and update passes over the cell chain sets the pace.
//   When the receiver stalls, the result waits in the output register and
//   the next operation still runs up to its result stage, then holds there.
//   Reset empties the queue (all valid bits clear); stored words are
//   undefined until written and never read while invalid.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_unit
  import dqs_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // [1:0] status, [2] found, [34:3] front_value,
                                      // [66:35] back_value, [71:67] count,
                                      // [72] is_empty, [79:73] zero
);

  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam int unsigned ResW = StatusW + 1 + 2 * DataW + CountW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]         state_q, state_d;
  op_e                op_q;
  logic [DataW-1:0]   value_q;
  logic [OccW-1:0]    occ_q, occ_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               found_q, found_d;
  logic               upd;
  cell_cmd_t          cmd;

  logic [DataW-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] seen;
  logic             any_match;
  logic             full, empty;

  logic               m_valid_q;
  logic [ResW-1:0]    m_data_q;
  logic [DataW-1:0]   front_w, back_w;
  logic [CountW-1:0]  count_w;

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataW-1:0] ld, rd;
    logic             lv, rv;
    if (i == 0) begin : g_first
      assign ld = value_q;          // push front enters here
      assign lv = 1'b1;
    end else begin : g_mid_l
      assign ld = cell_data[i-1];
      assign lv = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rd = '0;
      assign rv = 1'b0;
    end else begin : g_mid_r
      assign rd = cell_data[i+1];
      assign rv = cell_valid[i+1];
    end
    // prefix of registered match flags: cells at or after the first match shift
    assign seen[i] = |cell_match[i:0];

    dqs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .value_i      (value_q),
      .left_data_i  (ld),
      .left_valid_i (lv),
      .right_data_i (rd),
      .right_valid_i(rv),
      .seen_i       (seen[i]),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (cell_match[i])
    );
  end

  assign any_match = |cell_match;
  assign full      = cell_valid[DEPTH-1];
  assign empty     = ~cell_valid[0];

  assign cmd.cmp = (state_q == S_CMP);
  assign cmd.upd = upd;
  assign cmd.op  = op_q;

  // ---------------- operation decode, update pass ----------------
  always_comb begin
    status_d = status_q;
    found_d  = found_q;
    occ_d    = occ_q;
    upd      = 1'b0;
    if (state_q == S_UPD) begin
      status_d = STATUS_OK;
      found_d  = 1'b0;
      unique case (op_q)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            upd   = 1'b1;
            occ_d = occ_q + OccW'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            upd   = 1'b1;
            occ_d = occ_q - OccW'(1);
          end
        end
        OP_LOOKUP: begin
          found_d = any_match;
          if (!any_match) begin
            status_d = STATUS_MISSING;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else if (!any_match) begin
            status_d = STATUS_MISSING;
          end else begin
            upd     = 1'b1;
            found_d = 1'b1;
            occ_d   = occ_q - OccW'(1);
          end
        end
        default: begin
          // unused codes: no operation, status ok
        end
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  state_d = S_RES;
      S_RES:  if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= op_e'(s_axis_tuser);
      value_q <= s_axis_tdata;
    end
    status_q <= status_d;
    found_q  <= found_d;
  end

  // ---------------- result formation ----------------
  // Back word: the one valid cell whose right neighbor is empty.
  always_comb begin
    back_w = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && (i == DEPTH - 1 || !cell_valid[(i + 1) % DEPTH])) begin
        back_w = back_w | cell_data[i];
      end
    end
  end

  assign front_w = cell_valid[0] ? cell_data[0] : '0;

  if (OccW >= CountW) begin : g_cnt_trunc
    assign count_w = occ_q[CountW-1:0];
  end else begin : g_cnt_ext
    assign count_w = {{(CountW - OccW){1'b0}}, occ_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_RES && (!m_valid_q || m_axis_tready)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RES && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {~cell_valid[0], count_w, back_w, front_w, found_q, status_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(80 - ResW){1'b0}}, m_data_q};

endmodule

>>> sv/dqs_checker.sv
// ----------------------------------------------------------------------------
// Deque search unit checker
// Port-level properties of the deque search unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_search_unit_defines.svh"

module dqs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // a held result does not change
  `DQS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // one operation in flight: busy right after an input transfer
  `DQS_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // an empty queue reports zero words and zero count
  `DQS_ASSERT_NOW(a_empty, m_axis_tvalid && m_axis_tdata[72], m_axis_tdata[71:67] == 5'd0 && m_axis_tdata[66:3] == 64'd0)
  // a match always comes with ok status
  `DQS_ASSERT_NOW(a_found, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1:0] == 2'd0)

endmodule

bind double_ended_queue_with_search_unit dqs_checker u_dqs_checker (.*);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Double-ended queue with search unit testbench
// Streams push, pop, lookup and remove operations into the deque engine,
// keeps a shadow deque, and checks every result field on the output stream.
// ----------------------------------------------------------------------------
module testbench
  import dqs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = DefaultDepth;

  // One operation to send, or a marker that makes the sender wait until
  // every outstanding result has come back.
  typedef struct packed {
    logic        sync;
    op_e         op;
    logic [31:0] value;
  } op_request_t;

  // Deque as seen after one operation; mirrors the m_axis_tdata layout
  // (first member in the highest bits).
  typedef struct packed {
    logic        is_empty;
    logic [4:0]  count;
    logic [31:0] back_word;
    logic [31:0] front_word;
    logic        found;
    logic [1:0]  status;
  } deque_snapshot_t;

  // Operation mixes for the random segments.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN,
    MIX_SEARCH
  } op_mix_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] value
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;         // [1:0] status, [2] found, [34:3] front_value,
                                     // [66:35] back_value, [71:67] count,
                                     // [72] is_empty, [79:73] zero

  op_request_t     op_requests[$];      // waiting to be offered
  deque_snapshot_t deque_snapshots[$];  // predicted, not yet seen on the output
  logic [31:0]     model_words[$];      // shadow deque, front at index 0

  logic in_xfer  = 1'b0;  // input transfer at the last rising edge
  logic out_xfer = 1'b0;  // output transfer at the last rising edge
  logic hold_off = 1'b0;  // receiver stalled for a long stretch
  int   src_wait    = 0;
  int   sink_wait   = 0;
  bit   src_steady  = 1'b0;
  bit   sink_steady = 1'b0;
  int   ops_accepted = 0;
  int   mismatches   = 0;

  double_ended_queue_with_search_unit #(
    .DEPTH(Depth)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow deque: applies one operation and returns the resulting view.
  // Error cases leave the contents untouched.
  // --------------------------------------------------------------------------
  function automatic deque_snapshot_t deque_after_op(op_e op, logic [31:0] value);
    deque_snapshot_t snap;
    int              hit;
    snap        = '0;
    snap.status = STATUS_OK;
    hit         = -1;
    // first match counted from the front
    foreach (model_words[i]) begin
      if (hit < 0 && model_words[i] == value) hit = i;
    end
    case (op)
      OP_PUSH_FRONT: begin
        if (model_words.size() >= Depth) snap.status = STATUS_FULL;
        else model_words.push_front(value);
      end
      OP_PUSH_BACK: begin
        if (model_words.size() >= Depth) snap.status = STATUS_FULL;
        else model_words.push_back(value);
      end
      OP_POP_FRONT: begin
        if (model_words.size() == 0) snap.status = STATUS_EMPTY;
        else void'(model_words.pop_front());
      end
      OP_POP_BACK: begin
        if (model_words.size() == 0) snap.status = STATUS_EMPTY;
        else void'(model_words.pop_back());
      end
      OP_LOOKUP: begin
        // an empty deque simply has no match
        if (hit >= 0) snap.found = 1'b1;
        else snap.status = STATUS_MISSING;
      end
      OP_REMOVE: begin
        if (model_words.size() == 0) begin
          snap.status = STATUS_EMPTY;
        end else if (hit < 0) begin
          snap.status = STATUS_MISSING;
        end else begin
          model_words.delete(hit);
          snap.found = 1'b1;
        end
      end
      default: ;
    endcase
    if (model_words.size() != 0) begin
      snap.front_word = model_words[0];
      snap.back_word  = model_words[model_words.size() - 1];
    end
    snap.count    = 5'(model_words.size());
    snap.is_empty = (model_words.size() == 0);
    return snap;
  endfunction

  task automatic check_snapshot(deque_snapshot_t want, deque_snapshot_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      mismatches++;
    end
    if (got.front_word !== want.front_word) begin
      $error("front_value: expected %0d, got %0d",
             $signed(want.front_word), $signed(got.front_word));
      mismatches++;
    end
    if (got.back_word !== want.back_word) begin
      $error("back_value: expected %0d, got %0d",
             $signed(want.back_word), $signed(got.back_word));
      mismatches++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      mismatches++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sees both streams at the rising edge. Inputs only move on the
  // falling edge, so the values read here are the ones that were sampled.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_xfer  <= 1'b0;
      out_xfer <= 1'b0;
    end else begin
      in_xfer  <= s_axis_tvalid && s_axis_tready;
      out_xfer <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        deque_snapshots.push_back(deque_after_op(op_e'(s_axis_tuser), s_axis_tdata));
        ops_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (deque_snapshots.size() == 0) begin
          $error("result transfer with no operation outstanding: tdata %h",
                 m_axis_tdata);
          mismatches++;
        end else begin
          check_snapshot(deque_snapshots.pop_front(), deque_snapshot_t'(m_axis_tdata[72:0]));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offers one operation at a time from op_requests. After each
  // transfer it idles for a random pause, except during steady stretches.
  // A sync marker holds it off until the output side has caught up.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && in_xfer) begin
        if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
        src_wait = src_steady ? 0 : $urandom_range(0, 19);
      end
      if (!s_axis_tvalid || in_xfer) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (op_requests.size() != 0 && op_requests[0].sync) begin
          s_axis_tvalid <= 1'b0;
          if (deque_snapshots.size() == 0) void'(op_requests.pop_front());
        end else if (op_requests.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= op_requests[0].op;
          s_axis_tdata  <= op_requests[0].value;
          void'(op_requests.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready drops for a random pause after each result transfer,
  // and for the whole of a long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_xfer) begin
        if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
        sink_wait = sink_steady ? 0 : $urandom_range(0, 19);
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long receiver stalls while the sender keeps going: the engine holds a
  // finished result plus the next one and then backs up its input.
  initial begin
    while (ops_accepted < 400) @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (250) @(negedge clk_i);
    hold_off <= 1'b0;
    while (ops_accepted < 1200) @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (250) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_op(op_e op, logic [31:0] value);
    op_requests.push_back('{sync: 1'b0, op: op, value: value});
  endfunction

  function automatic void queue_sync();
    op_requests.push_back('{sync: 1'b1, op: OP_LOOKUP, value: '0});
  endfunction

  function automatic op_e pick_op(op_mix_e mix);
    int push_pct;
    int pop_pct;
    int look_pct;
    int r;
    case (mix)
      MIX_FILL:  begin push_pct = 70; pop_pct = 10; look_pct = 10; end
      MIX_DRAIN: begin push_pct = 20; pop_pct = 55; look_pct = 10; end
      MIX_EVEN:  begin push_pct = 40; pop_pct = 30; look_pct = 15; end
      default:   begin push_pct = 30; pop_pct = 10; look_pct = 30; end
    endcase
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    if (r < push_pct + pop_pct + look_pct) return OP_LOOKUP;
    return OP_REMOVE;
  endfunction

  initial begin
    logic [31:0] pool[6];
    logic [31:0] word;
    op_mix_e     mix;
    int          seg_len;

    // Directed: every error case on an empty deque.
    queue_op(OP_POP_FRONT, 32'h0);
    queue_op(OP_POP_BACK, 32'hffff_ffff);
    queue_op(OP_REMOVE, 32'h7fff_ffff);
    queue_op(OP_LOOKUP, 32'h8000_0000);
    // Fill from both ends with extremes and duplicates of -1.
    for (int i = 0; i < Depth; i++) begin
      case (i % 4)
        0:       word = 32'h7fff_ffff;
        1:       word = 32'h8000_0000;
        2:       word = 32'hffff_ffff;
        default: word = 32'(i);
      endcase
      queue_op((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, word);
    end
    // Full: both pushes bounce.
    queue_op(OP_PUSH_FRONT, 32'h1);
    queue_op(OP_PUSH_BACK, 32'h2);
    queue_op(OP_LOOKUP, 32'h8000_0000);   // present
    queue_op(OP_LOOKUP, 32'h1234_5678);   // absent
    queue_op(OP_REMOVE, 32'h1234_5678);   // absent, no change
    queue_op(OP_REMOVE, 32'hffff_ffff);   // first of several copies
    queue_op(OP_POP_FRONT, 32'h0);
    queue_op(OP_POP_BACK, 32'h0);
    queue_sync();

    // Random segments. A small value pool per segment keeps lookups and
    // removes hitting stored words; a few full-range values go in as well.
    for (int n = 28; n < 1850; n += seg_len) begin
      mix     = op_mix_e'($urandom_range(0, 3));
      seg_len = $urandom_range(20, 80);
      foreach (pool[k]) begin
        case ($urandom_range(0, 5))
          0:       pool[k] = 32'h7fff_ffff;
          1:       pool[k] = 32'h8000_0000;
          2:       pool[k] = $urandom_range(0, 7);
          default: pool[k] = $urandom();
        endcase
      end
      for (int j = 0; j < seg_len; j++) begin
        word = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 5)];
        queue_op(pick_op(mix), word);
      end
      if ($urandom_range(0, 4) == 0) queue_sync();
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything offered, accepted and answered, then a short
    // grace period to catch stray results.
    while (op_requests.size() != 0 || s_axis_tvalid || deque_snapshots.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #12ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> double_ended_queue_with_search_unit.f
+incdir+sv
sv/dqs_pkg.sv
sv/dqs_cell.sv
sv/double_ended_queue_with_search_unit.sv
sv/dqs_checker.sv
tb/sv/testbench.sv
